@@ hdl/olu_pkg.sv @@
// ----------------------------------------------------------------------------
// olu_pkg
// Shared codes and the result payload type of the ordered value list unit.
// ----------------------------------------------------------------------------
package olu_pkg;

   localparam int VALUE_W     = 32;
   localparam int COUNT_W     = 6;
   localparam int MAX_RESULTS = 32;

   localparam logic [1:0] MODE_APPEND  = 2'd0;
   localparam logic [1:0] MODE_PREPEND = 2'd1;
   localparam logic [1:0] MODE_DELETE  = 2'd2;
   localparam logic [1:0] MODE_LIST    = 2'd3;

   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
   localparam logic [1:0] STAT_FULL      = 2'd2;
   localparam logic [1:0] STAT_EMPTY     = 2'd3;

   typedef struct packed {
      logic [1:0]         status;
      logic [VALUE_W-1:0] element;
      logic               last;
      logic [COUNT_W-1:0] count;
   } rsp_type;

endpackage

@@ hdl/ordered_value_list_unit.sv @@
// ----------------------------------------------------------------------------
// ordered_value_list_unit
// Bounded ordered list of signed values held in a circular entry memory.
// ----------------------------------------------------------------------------
// One transaction is worked on at a time; req_ready is high only while the
// unit is idle. A push is accepted, then gives its result. A delete walks
// the memory one read per cycle to find the match, then compacts the later
// entries one read and one write per cycle, then gives its result. Search
// and compaction together pass each entry once. A list gives one result per
// cycle while rsp_ready is held high, after a memory read, never more than
// 32 results. The walk over the single read port of the entry memory sets
// these rates. The memory needs no clearing after reset.
module ordered_value_list_unit #(
   parameter int CAPACITY = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_mode,
   input  logic signed [olu_pkg::VALUE_W-1:0] req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [1:0]                         rsp_status,
   output logic signed [olu_pkg::VALUE_W-1:0] rsp_element,
   output logic                               rsp_last,
   output logic [olu_pkg::COUNT_W-1:0]        rsp_count
);

   localparam int IW       = $clog2(CAPACITY);
   localparam int CW       = $clog2(CAPACITY + 1);
   localparam int LIST_MAX = (CAPACITY < olu_pkg::MAX_RESULTS) ? CAPACITY
                                                               : olu_pkg::MAX_RESULTS;
   localparam logic [CW-1:0] CAP_C      = CW'(CAPACITY);
   localparam logic [CW-1:0] LIST_MAX_C = CW'(LIST_MAX);
   localparam logic [IW-1:0] LAST_IDX   = IW'(CAPACITY - 1);
   localparam logic [IW:0]   CAP_WIDE   = (IW+1)'(CAPACITY);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_EMIT   = 3'd1;
   localparam logic [2:0] ST_SEARCH = 3'd2;
   localparam logic [2:0] ST_SHIFT  = 3'd3;
   localparam logic [2:0] ST_LIST   = 3'd4;

   function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] front,
                                             input logic [IW-1:0] pos);
      logic [IW:0] sum;
      sum = {1'b0, front} + {1'b0, pos};
      if (sum >= CAP_WIDE) begin
         sum = sum - CAP_WIDE;
      end
      return sum[IW-1:0];
   endfunction

   logic [2:0]                  state_ff, state_in;
   logic [IW-1:0]               front_ff, front_in;
   logic [CW-1:0]               count_ff, count_in;
   logic                        pend_ff, pend_in;
   logic [CW-1:0]               pend_pos_ff, pend_pos_in;
   logic [CW-1:0]               pos_ff, pos_in;
   logic [olu_pkg::VALUE_W-1:0] value_ff, value_in;
   logic [1:0]                  status_ff, status_in;

   logic                        mem_wr_en;
   logic [IW-1:0]               mem_wr_addr;
   logic [olu_pkg::VALUE_W-1:0] mem_wr_data;
   logic                        mem_rd_en;
   logic [IW-1:0]               mem_rd_addr;
   logic [olu_pkg::VALUE_W-1:0] mem_rd_data;

   logic                        rsp_load;
   logic                        rsp_free;
   olu_pkg::rsp_type            rsp_data_in;
   olu_pkg::rsp_type            rsp_data;

   logic [CW-1:0]               list_len;
   logic [CW-1:0]               dst_pos;
   logic [IW-1:0]               front_prev;
   logic                        list_take;
   logic                        list_last;

   assign req_ready  = (state_ff == ST_IDLE);
   assign list_len   = (count_ff > LIST_MAX_C) ? LIST_MAX_C : count_ff;
   assign dst_pos    = pend_pos_ff - 1'b1;
   assign front_prev = (front_ff == '0) ? LAST_IDX : front_ff - 1'b1;
   assign list_take  = pend_ff && rsp_free;
   assign list_last  = ((pend_pos_ff + 1'b1) == list_len);

   always_comb begin
      state_in    = state_ff;
      front_in    = front_ff;
      count_in    = count_ff;
      pend_in     = pend_ff;
      pend_pos_in = pend_pos_ff;
      pos_in      = pos_ff;
      value_in    = value_ff;
      status_in   = status_ff;

      mem_wr_en   = 1'b0;
      mem_wr_addr = slot_of(front_ff, count_ff[IW-1:0]);
      mem_wr_data = value_ff;
      mem_rd_en   = 1'b0;
      mem_rd_addr = slot_of(front_ff, pos_ff[IW-1:0]);

      rsp_load    = 1'b0;
      rsp_data_in = '{status: status_ff, element: '0, last: 1'b1,
                      count: olu_pkg::COUNT_W'(count_ff)};

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               value_in = req_value;
               pos_in   = '0;
               pend_in  = 1'b0;
               case (req_mode)
                  olu_pkg::MODE_APPEND, olu_pkg::MODE_PREPEND: begin
                     if (count_ff == CAP_C) begin
                        status_in = olu_pkg::STAT_FULL;
                     end else begin
                        mem_wr_en   = 1'b1;
                        mem_wr_data = req_value;
                        if (req_mode == olu_pkg::MODE_PREPEND) begin
                           front_in    = front_prev;
                           mem_wr_addr = front_prev;
                        end
                        count_in  = count_ff + 1'b1;
                        status_in = olu_pkg::STAT_OK;
                     end
                     state_in = ST_EMIT;
                  end
                  olu_pkg::MODE_DELETE: begin
                     state_in = ST_SEARCH;
                  end
                  default: begin
                     if (count_ff == '0) begin
                        status_in = olu_pkg::STAT_EMPTY;
                        state_in  = ST_EMIT;
                     end else begin
                        state_in = ST_LIST;
                     end
                  end
               endcase
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SEARCH: begin
            if (pend_ff && (mem_rd_data == value_ff)) begin
               pos_in   = pend_pos_ff + 1'b1;
               pend_in  = 1'b0;
               state_in = ST_SHIFT;
            end else if (pos_ff < count_ff) begin
               mem_rd_en   = 1'b1;
               pend_in     = 1'b1;
               pend_pos_in = pos_ff;
               pos_in      = pos_ff + 1'b1;
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else begin
               status_in = olu_pkg::STAT_NOT_FOUND;
               state_in  = ST_EMIT;
            end
         end
         ST_SHIFT: begin
            // write back the entry read last cycle one place toward the front
            if (pend_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = slot_of(front_ff, dst_pos[IW-1:0]);
               mem_wr_data = mem_rd_data;
            end
            if (pos_ff < count_ff) begin
               mem_rd_en   = 1'b1;
               pend_in     = 1'b1;
               pend_pos_in = pos_ff;
               pos_in      = pos_ff + 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  count_in  = count_ff - 1'b1;
                  status_in = olu_pkg::STAT_OK;
                  state_in  = ST_EMIT;
               end
            end
         end
         ST_LIST: begin
            if (list_take) begin
               rsp_load    = 1'b1;
               rsp_data_in = '{status: olu_pkg::STAT_OK, element: mem_rd_data,
                               last: list_last, count: olu_pkg::COUNT_W'(count_ff)};
            end
            if ((pos_ff < list_len) && (!pend_ff || rsp_free)) begin
               mem_rd_en   = 1'b1;
               pend_in     = 1'b1;
               pend_pos_in = pos_ff;
               pos_in      = pos_ff + 1'b1;
            end else if (list_take) begin
               pend_in = 1'b0;
            end
            if (list_take && list_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         front_ff <= '0;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         front_ff <= front_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_pos_ff <= pend_pos_in;
      pos_ff      <= pos_in;
      value_ff    <= value_in;
      status_ff   <= status_in;
   end

   olu_store #(
      .DEPTH (CAPACITY),
      .AW    (IW)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   olu_rsp_reg u_rsp_reg (
      .clock   (clock),
      .reset   (reset),
      .load    (rsp_load),
      .data_in (rsp_data_in),
      .ready   (rsp_ready),
      .valid   (rsp_valid),
      .data    (rsp_data),
      .free    (rsp_free)
   );

   assign rsp_status  = rsp_data.status;
   assign rsp_element = $signed(rsp_data.element);
   assign rsp_last    = rsp_data.last;
   assign rsp_count   = rsp_data.count;

endmodule

@@ hdl/olu_store.sv @@
// ----------------------------------------------------------------------------
// olu_store
// Entry memory: one write port, one read port, registered read data that
// holds its value between reads.
// ----------------------------------------------------------------------------
module olu_store #(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [olu_pkg::VALUE_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [AW-1:0]               rd_addr,
   output logic [olu_pkg::VALUE_W-1:0] rd_data
);

   logic [olu_pkg::VALUE_W-1:0] mem [DEPTH];
   logic [olu_pkg::VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/olu_rsp_reg.sv @@
// ----------------------------------------------------------------------------
// olu_rsp_reg
// Result output register. Holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module olu_rsp_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  olu_pkg::rsp_type data_in,
   input  logic             ready,
   output logic             valid,
   output olu_pkg::rsp_type data,
   output logic             free
);

   logic             valid_ff;
   logic             valid_in;
   olu_pkg::rsp_type data_ff;

   assign free = !valid_ff || ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign valid = valid_ff;
   assign data  = data_ff;

endmodule

@@ hdl/olu_checker.sv @@
// ----------------------------------------------------------------------------
// olu_checker
// Port-level checks of the ordered value list unit, bound to the top level.
// ----------------------------------------------------------------------------
module olu_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [1:0]                         rsp_status,
   input logic signed [olu_pkg::VALUE_W-1:0] rsp_element,
   input logic                               rsp_last,
   input logic [olu_pkg::COUNT_W-1:0]        rsp_count
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_element) && $stable(rsp_last) && $stable(rsp_count))
      else $error("result changed while stalled");

   a_error_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != olu_pkg::STAT_OK) |-> rsp_last)
      else $error("error status on a non-final result");

   a_element_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_element != 0) |-> (rsp_status == olu_pkg::STAT_OK))
      else $error("nonzero element with error status");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == olu_pkg::STAT_EMPTY) |-> (rsp_count == '0))
      else $error("empty status with nonzero count");

   a_busy_listing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("new transaction accepted during a list");

endmodule

bind ordered_value_list_unit olu_checker u_olu_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_status  (rsp_status),
   .rsp_element (rsp_element),
   .rsp_last    (rsp_last),
   .rsp_count   (rsp_count)
);
